// File: rtl/knn_density_2d_assert.svh
// assertion macros for the knn density block
// used by rtl/knn_density_2d.sv, no other dependencies
`ifndef KNN_DENSITY_2D_ASSERT_SVH
`define KNN_DENSITY_2D_ASSERT_SVH
`ifndef ASSERT_OFF
`define KND_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("knn_density_2d: check failed");
`define KND_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("knn_density_2d: check failed");
`else
`define KND_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define KND_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/knd_pkg.sv
// shared types and constants of the knn density block
// no dependencies
`timescale 1ns / 1ps
package knd_pkg;
   localparam int DIST_W = 64;
   localparam logic [DIST_W-1:0] DIST_ONES = '1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_EVAL  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOT_LOADED  = 2'd1,
      ST_ZERO_RADIUS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_NEIGHBOUR_COUNT = 3'd0,
      REG_INV_NORM_X      = 3'd1,
      REG_INV_NORM_Y      = 3'd2,
      REG_MIN_RADIUS_SQ   = 3'd3,
      REG_DENSITY_SCALE   = 3'd4
   } reg_type;

   typedef struct packed {
      logic              le;
      logic [DIST_W-1:0] val;
   } link_type;

   typedef struct packed {
      logic d_valid;
      logic busy;
   } dist_stat_type;
endpackage

// File: rtl/knd_sort_cell.sv
// one cell of the sorted nearest-distance chain
// depends on knd_pkg
`timescale 1ns / 1ps
module knd_sort_cell (
   input  logic                      clock,
   input  logic                      clear,
   input  logic                      d_valid,
   input  logic [knd_pkg::DIST_W-1:0] d,
   input  knd_pkg::link_type         left,
   output knd_pkg::link_type         right
);
   logic [knd_pkg::DIST_W-1:0] val_ff, val_in;
   logic                       le;

   assign le = (d <= val_ff);

   always_comb begin
      val_in = val_ff;
      if (clear) begin
         val_in = knd_pkg::DIST_ONES;
      end else if (d_valid) begin
         if (left.le) begin
            val_in = left.val;
         end else if (le) begin
            val_in = d;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign right.le  = le;
   assign right.val = val_ff;
endmodule

// File: rtl/knd_dist.sv
// pipelined normalized squared distance between two points
// depends on knd_pkg
`timescale 1ns / 1ps
module knd_dist (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [23:0]         ax,
   input  logic signed [23:0]         ay,
   input  logic signed [23:0]         bx,
   input  logic signed [23:0]         by,
   input  logic [23:0]                inv_x,
   input  logic [23:0]                inv_y,
   output knd_pkg::dist_stat_type     stat,
   output logic [knd_pkg::DIST_W-1:0] d
);
   logic [4:0]  v_ff, v_in;
   logic [24:0] mag_ff [2];
   logic [48:0] n_ff [2];
   logic        big_ff [2];
   logic [39:0] hh_ff [2], hl_ff [2], ll_ff [2];
   logic [63:0] sq_ff [2];
   logic [63:0] d_ff;
   logic signed [24:0] dx, dy;
   logic [64:0] sum;

   assign dx = 25'(ax) - 25'(bx);
   assign dy = 25'(ay) - 25'(by);
   assign sum = 65'(sq_ff[0]) + 65'(sq_ff[1]);
   assign v_in = {v_ff[3:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff[0] <= dx[24] ? 25'(-dx) : 25'(dx);
      mag_ff[1] <= dy[24] ? 25'(-dy) : 25'(dy);
      n_ff[0]   <= 49'(mag_ff[0]) * 49'(inv_x);
      n_ff[1]   <= 49'(mag_ff[1]) * 49'(inv_y);
      for (int i = 0; i < 2; i++) begin
         big_ff[i] <= (n_ff[i][48:40] != '0);
         hh_ff[i]  <= 40'(n_ff[i][39:20]) * 40'(n_ff[i][39:20]);
         hl_ff[i]  <= 40'(n_ff[i][39:20]) * 40'(n_ff[i][19:0]);
         ll_ff[i]  <= 40'(n_ff[i][19:0]) * 40'(n_ff[i][19:0]);
         sq_ff[i]  <= big_ff[i] ? knd_pkg::DIST_ONES :
                      (64'(hh_ff[i]) << 24) + (64'(hl_ff[i]) << 5) + 64'(ll_ff[i][39:16]);
      end
      d_ff <= sum[64] ? knd_pkg::DIST_ONES : sum[63:0];
   end

   assign d            = d_ff;
   assign stat.d_valid = v_ff[4];
   assign stat.busy    = |v_ff;
endmodule

// File: rtl/knd_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module knd_div #(
   parameter int NW = 48,
   parameter int DW = 57
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CNTW = $clog2(NW + 1);
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in, den_ff;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]     shifted, diff;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         cnt_in  = CNTW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

// File: rtl/knn_density_2d.sv
// k-nearest-neighbour density estimate over a store of 2-D points
// evaluate: a walk over the stored points, then a 48-step divide where one is needed
// load and clear leave the block idle; one item in flight at a time
// throughput set by the single read port of the point memory, one point per cycle
// reset: synchronous, clears store count, registers to defaults, no clearing pass
// depends on knd_pkg, knd_sort_cell, knd_dist, knd_div, knn_density_2d_assert.svh
`timescale 1ns / 1ps
`include "knn_density_2d_assert.svh"
module knn_density_2d #(
   parameter int MAX_POINTS = 256,
   parameter int MAX_K      = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [23:0] req_x_coord,
   input  logic signed [23:0] req_y_coord,
   input  logic [7:0]         req_point_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_density,
   output logic [63:0]        rsp_kth_distance_sq,
   output logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [5:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);
   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int IW  = (CW > 8) ? CW : 8;
   localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int DW  = CW + 48;
   localparam int DLW = knd_pkg::DIST_W;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_FETCH = 9'b000000010,
      S_WALK  = 9'b000000100,
      S_DRAIN = 9'b000001000,
      S_PICK  = 9'b000010000,
      S_CHECK = 9'b000100000,
      S_MUL   = 9'b001000000,
      S_DIV   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]  nc_ff;
   logic [23:0] invx_ff, invy_ff;
   logic [47:0] minr_ff;
   logic [31:0] scale_ff;

   logic [47:0]    mem [MAX_POINTS];
   logic [47:0]    rd_ff, pt_ff, pt_in;
   logic [AW-1:0]  rd_addr;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  j_ff, j_in;
   logic [IW-1:0]  idx_ff, idx_in, req_idx;
   logic           v1_ff, v1_in, issue, load_we, clear_cells, accept;
   logic [DLW-1:0] dk_ff, dk_in, r2;
   logic [CW+23:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [31:0]    res_density_ff, res_density_in;
   logic [DLW-1:0] res_dist_ff, res_dist_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [31:0]    rsp_density_ff;
   logic [DLW-1:0] rsp_dist_ff;
   logic [1:0]     rsp_status_ff;
   logic [47:0]    num;
   logic [DW-1:0]  den;
   logic           div_start, div_done;
   logic [47:0]    quo;
   logic [6:0]     kraw, kcap;
   logic [KW-1:0]  ksel;
   logic [DLW-1:0] dist_d;
   knd_pkg::dist_stat_type dist_stat;
   knd_pkg::link_type      link [MAX_K+1];
   logic [DLW-1:0]         entry [MAX_K];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff    <= 5'd2;
         invx_ff  <= 24'd65536;
         invy_ff  <= 24'd65536;
         minr_ff  <= 48'd65536;
         scale_ff <= 32'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[5:3])
            knd_pkg::REG_NEIGHBOUR_COUNT: nc_ff    <= csr_pwdata[4:0];
            knd_pkg::REG_INV_NORM_X:      invx_ff  <= csr_pwdata[23:0];
            knd_pkg::REG_INV_NORM_Y:      invy_ff  <= csr_pwdata[23:0];
            knd_pkg::REG_MIN_RADIUS_SQ:   minr_ff  <= csr_pwdata[47:0];
            knd_pkg::REG_DENSITY_SCALE:   scale_ff <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[5:3])
         knd_pkg::REG_NEIGHBOUR_COUNT: csr_prdata = 64'(nc_ff);
         knd_pkg::REG_INV_NORM_X:      csr_prdata = 64'(invx_ff);
         knd_pkg::REG_INV_NORM_Y:      csr_prdata = 64'(invy_ff);
         knd_pkg::REG_MIN_RADIUS_SQ:   csr_prdata = 64'(minr_ff);
         knd_pkg::REG_DENSITY_SCALE:   csr_prdata = 64'(scale_ff);
         default:                      csr_prdata = '0;
      endcase
   end
   assign csr_pready = 1'b1;

   // list length select
   assign kraw = (nc_ff <= 5'd1) ? 7'd0 : 7'(nc_ff) - 7'd2;
   assign kcap = (kraw > 7'(MAX_K - 1)) ? 7'(MAX_K - 1) : kraw;
   assign ksel = kcap[KW-1:0];

   assign accept  = req_valid && req_ready;
   assign req_idx = IW'(req_point_index);
   assign load_we = accept && (req_cmd == knd_pkg::CMD_LOAD) && (count_ff < CW'(MAX_POINTS));
   assign num     = {scale_ff, 16'd0};
   assign r2      = (dk_ff > 64'(minr_ff)) ? dk_ff : 64'(minr_ff);
   assign den     = (DW'(phi_ff) << 24) + DW'(plo_ff);

   // point memory
   always_ff @(posedge clock) begin
      if (load_we) begin
         mem[count_ff[AW-1:0]] <= {req_x_coord, req_y_coord};
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      j_in           = j_ff;
      idx_in         = idx_ff;
      pt_in          = pt_ff;
      dk_in          = dk_ff;
      plo_in         = plo_ff;
      phi_in         = phi_ff;
      res_density_in = res_density_ff;
      res_dist_in    = res_dist_ff;
      res_status_in  = res_status_ff;
      rd_addr        = j_ff;
      issue          = 1'b0;
      clear_cells    = 1'b0;
      div_start      = 1'b0;
      rsp_load       = 1'b0;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = req_idx[AW-1:0];
            if (accept) begin
               case (req_cmd)
                  knd_pkg::CMD_LOAD: begin
                     if (load_we) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  knd_pkg::CMD_CLEAR: count_in = '0;
                  knd_pkg::CMD_EVAL: begin
                     idx_in = req_idx;
                     j_in   = '0;
                     if (req_idx >= IW'(count_ff)) begin
                        res_density_in = '0;
                        res_dist_in    = knd_pkg::DIST_ONES;
                        res_status_in  = knd_pkg::ST_NOT_LOADED;
                        state_in       = S_DONE;
                     end else begin
                        clear_cells = 1'b1;
                        state_in    = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH, S_WALK: begin
            if (state_ff == S_FETCH) begin
               pt_in = rd_ff;
            end
            issue = 1'b1;
            j_in  = j_ff + 1'b1;
            if (CW'(j_ff) == count_ff - 1'b1) begin
               state_in = S_DRAIN;
            end else begin
               state_in = S_WALK;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !dist_stat.busy) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            dk_in    = entry[ksel];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            res_dist_in = dk_ff;
            if (r2 == '0) begin
               res_density_in = '1;
               res_status_in  = knd_pkg::ST_ZERO_RADIUS;
               state_in       = S_DONE;
            end else if (r2 > 64'(num)) begin
               res_density_in = '0;
               res_status_in  = knd_pkg::ST_OK;
               state_in       = S_DONE;
            end else begin
               plo_in   = (CW+24)'(count_ff) * (CW+24)'(r2[23:0]);
               phi_in   = (CW+24)'(count_ff) * (CW+24)'(r2[47:24]);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               res_density_in = (quo[47:32] != '0) ? '1 : quo[31:0];
               res_status_in  = knd_pkg::ST_OK;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign v1_in        = issue && (IW'(j_ff) != idx_ff);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff           <= j_in;
      idx_ff         <= idx_in;
      pt_ff          <= pt_in;
      dk_ff          <= dk_in;
      plo_ff         <= plo_in;
      phi_ff         <= phi_in;
      res_density_ff <= res_density_in;
      res_dist_ff    <= res_dist_in;
      res_status_ff  <= res_status_in;
      if (rsp_load) begin
         rsp_density_ff <= res_density_ff;
         rsp_dist_ff    <= res_dist_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   knd_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff),
      .ax       (pt_ff[47:24]),
      .ay       (pt_ff[23:0]),
      .bx       (rd_ff[47:24]),
      .by       (rd_ff[23:0]),
      .inv_x    (invx_ff),
      .inv_y    (invy_ff),
      .stat     (dist_stat),
      .d        (dist_d)
   );

   assign link[0].le  = 1'b0;
   assign link[0].val = knd_pkg::DIST_ONES;

   for (genvar l = 0; l < MAX_K; l++) begin : g_cell
      knd_sort_cell u_cell (
         .clock   (clock),
         .clear   (clear_cells),
         .d_valid (dist_stat.d_valid),
         .d       (dist_d),
         .left    (link[l]),
         .right   (link[l+1])
      );
      assign entry[l] = link[l+1].val;
   end

   knd_div #(.NW(48), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quo   (quo)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_density         = rsp_density_ff;
   assign rsp_kth_distance_sq = rsp_dist_ff;
   assign rsp_status          = rsp_status_ff;

   `KND_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CW'(MAX_POINTS))
   `KND_ASSERT_IMPL(a_div_state, clock, reset, div_done, state_ff == S_DIV)
   `KND_ASSERT_IMPL(a_idle_quiet, clock, reset, state_ff == S_IDLE, !dist_stat.busy && !v1_ff)
   `KND_ASSERT_NEXT(a_not_loaded, clock, reset, rsp_load && res_status_ff == knd_pkg::ST_NOT_LOADED, rsp_density == '0 && rsp_kth_distance_sq == knd_pkg::DIST_ONES)
endmodule

// File: bench/tb_knn_density_2d.sv
// self-checking bench for knn_density_2d: directed and random load, evaluate and clear items
// predicts densities from its own copy of the point store and registers
// depends on knd_pkg and the knn_density_2d rtl
`timescale 1ns / 1ps
module tb_knn_density_2d;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int STORE_DEPTH = 256;
   localparam int LIST_DEPTH = 16;
   localparam int SETTLE_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [7:0]         idx;
   } point_item_type;

   typedef struct {
      logic [31:0] density;
      logic [63:0] kth;
      logic [1:0]  status;
   } density_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_cmd = 0;
   logic signed [23:0] req_x_coord = 0;
   logic signed [23:0] req_y_coord = 0;
   logic [7:0] req_point_index = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [31:0] rsp_density;
   logic [63:0] rsp_kth_distance_sq;
   logic [1:0] rsp_status;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [5:0] csr_paddr = 0;
   logic [63:0] csr_pwdata = 0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   knn_density_2d u_top (.*);

   point_item_type pending_items[$];
   density_result_type expected_densities[$];
   point_item_type driven_item;
   int errors = 0;

   // mirror of the block state
   logic [4:0] k_reg;
   logic [23:0] inv_x_reg, inv_y_reg;
   logic [47:0] min_r2_reg;
   logic [31:0] scale_reg;
   logic signed [23:0] store_x[STORE_DEPTH];
   logic signed [23:0] store_y[STORE_DEPTH];
   int store_count = 0;
   int gen_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] norm_dist_sq(logic signed [23:0] a, logic signed [23:0] b,
                                               logic [23:0] inv);
      logic signed [25:0] diff;
      logic [24:0] mag;
      logic [48:0] prod;
      logic [127:0] sq;
      diff = 26'(a) - 26'(b);
      mag = diff < 0 ? 25'(-diff) : 25'(diff);
      prod = 49'(mag) * 49'(inv);
      if (prod >= 49'h100_0000_0000) return '1;
      sq = 128'(prod) * 128'(prod);
      return sq[79:16];
   endfunction

   task automatic apply_item(point_item_type it);
      density_result_type res;
      logic [63:0] nearest[LIST_DEPTH];
      logic [63:0] d, sx, sy, r2, num, q;
      int kk;
      case (it.cmd)
         knd_pkg::CMD_LOAD: begin
            if (store_count < STORE_DEPTH) begin
               store_x[store_count] = it.x;
               store_y[store_count] = it.y;
               store_count++;
            end
         end
         knd_pkg::CMD_CLEAR: store_count = 0;
         knd_pkg::CMD_EVAL: begin
            if (it.idx >= store_count) begin
               res.density = 0;
               res.kth = '1;
               res.status = knd_pkg::ST_NOT_LOADED;
            end else begin
               kk = k_reg > 1 ? k_reg - 1 : 1;
               if (kk > LIST_DEPTH) kk = LIST_DEPTH;
               foreach (nearest[l]) nearest[l] = '1;
               for (int j = 0; j < store_count; j++) begin
                  if (j == it.idx) continue;
                  sx = norm_dist_sq(store_x[it.idx], store_x[j], inv_x_reg);
                  sy = norm_dist_sq(store_y[it.idx], store_y[j], inv_y_reg);
                  d = sx + sy;
                  if (d < sx) d = '1;
                  for (int l = 0; l < kk; l++) begin
                     if (d <= nearest[l]) begin
                        for (int m = kk - 1; m > l; m--) nearest[m] = nearest[m-1];
                        nearest[l] = d;
                        break;
                     end
                  end
               end
               res.kth = nearest[kk-1];
               r2 = res.kth > {16'b0, min_r2_reg} ? res.kth : {16'b0, min_r2_reg};
               num = {16'b0, scale_reg, 16'b0};
               if (r2 == 0) begin
                  res.density = '1;
                  res.status = knd_pkg::ST_ZERO_RADIUS;
               end else begin
                  res.status = knd_pkg::ST_OK;
                  if (r2 > num) res.density = 0;
                  else begin
                     q = num / (64'(store_count) * r2);
                     res.density = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
                  end
               end
            end
            expected_densities.push_back(res);
         end
         default: ;
      endcase
   endtask

   // sender
   int send_gap = 0;
   bit send_burst = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) apply_item(driven_item);
         if (!req_valid || req_ready) begin
            if ($urandom_range(0, 99) < 2) send_burst = !send_burst;
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 0;
            end else if (pending_items.size() > 0) begin
               driven_item = pending_items.pop_front();
               req_valid <= 1;
               req_cmd <= driven_item.cmd;
               req_x_coord <= driven_item.x;
               req_y_coord <= driven_item.y;
               req_point_index <= driven_item.idx;
               if (send_burst || $urandom_range(0, 99) < 60) send_gap <= 0;
               else if ($urandom_range(0, 99) < 85) send_gap <= $urandom_range(1, 3);
               else send_gap <= $urandom_range(10, 60);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // receiver, with one long hold-off on request
   int recv_stall = 0;
   int hold_cnt = 0;
   bit hold_go = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1;
         hold_cnt <= 1500;
         rsp_ready <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if ($urandom_range(0, 99) < 15)
            recv_stall <= $urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 60);
      end
   end

   // result checker
   density_result_type exp_res;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_densities.size() == 0) begin
            $display("%0t: result with none expected: density %h kth %h status %0d",
                     $time, rsp_density, rsp_kth_distance_sq, rsp_status);
            errors++;
         end else begin
            exp_res = expected_densities.pop_front();
            if (rsp_density !== exp_res.density) begin
               $display("%0t: density expected %h actual %h", $time, exp_res.density,
                        rsp_density);
               errors++;
            end
            if (rsp_kth_distance_sq !== exp_res.kth) begin
               $display("%0t: kth_distance_sq expected %h actual %h", $time, exp_res.kth,
                        rsp_kth_distance_sq);
               errors++;
            end
            if (rsp_status !== exp_res.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                        rsp_status);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("knn_density_2d test failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic csr_write(knd_pkg::reg_type r, logic [63:0] v);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 6'(r) << 3;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (r)
         knd_pkg::REG_NEIGHBOUR_COUNT: k_reg = v[4:0];
         knd_pkg::REG_INV_NORM_X:      inv_x_reg = v[23:0];
         knd_pkg::REG_INV_NORM_Y:      inv_y_reg = v[23:0];
         knd_pkg::REG_MIN_RADIUS_SQ:   min_r2_reg = v[47:0];
         knd_pkg::REG_DENSITY_SCALE:   scale_reg = v[31:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [4:0] k, logic [23:0] ix, logic [23:0] iy,
                             logic [47:0] mr, logic [31:0] sc);
      csr_write(knd_pkg::REG_NEIGHBOUR_COUNT, 64'(k));
      csr_write(knd_pkg::REG_INV_NORM_X, 64'(ix));
      csr_write(knd_pkg::REG_INV_NORM_Y, 64'(iy));
      csr_write(knd_pkg::REG_MIN_RADIUS_SQ, 64'(mr));
      csr_write(knd_pkg::REG_DENSITY_SCALE, 64'(sc));
   endtask

   task automatic push_item(logic [1:0] cmd, logic signed [23:0] x, logic signed [23:0] y,
                            logic [7:0] idx);
      point_item_type it;
      it.cmd = cmd;
      it.x = x;
      it.y = y;
      it.idx = idx;
      pending_items.push_back(it);
      if (cmd == knd_pkg::CMD_LOAD && gen_count < STORE_DEPTH) gen_count++;
      if (cmd == knd_pkg::CMD_CLEAR) gen_count = 0;
   endtask

   function automatic logic signed [23:0] rand_coord();
      if ($urandom_range(0, 9) == 0) return 24'($urandom);
      return 24'($signed($urandom_range(0, 4000)) - 2000);
   endfunction

   function automatic logic [7:0] rand_index();
      if (gen_count == 0 || $urandom_range(0, 9) == 0) return 8'($urandom);
      return 8'($urandom_range(0, gen_count - 1));
   endfunction

   task automatic drain();
      wait (pending_items.size() == 0 && !req_valid && expected_densities.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_inv();
      case ($urandom_range(0, 5))
         0: return 24'd1;
         1: return 24'hFF_FFFF;
         default: return 24'($urandom_range(16, 1 << 18));
      endcase
   endfunction

   function automatic logic [47:0] rand_min_r2();
      case ($urandom_range(0, 4))
         0: return 48'd0;
         1: return 48'hFFFF_FFFF_FFFF;
         2: return 48'($urandom_range(1, 1 << 20));
         default: return 48'({$urandom, $urandom} >> $urandom_range(16, 63));
      endcase
   endfunction

   initial begin
      logic [4:0] k;
      k_reg = 2;
      inv_x_reg = 65536;
      inv_y_reg = 65536;
      min_r2_reg = 65536;
      scale_reg = 65536;
      repeat (12) @(posedge clock);
      reset <= 0;

      // defaults: empty store, single point, coordinate extremes, unused command
      push_item(knd_pkg::CMD_CLEAR, 0, 0, 0);
      push_item(knd_pkg::CMD_EVAL, 0, 0, 0);
      push_item(knd_pkg::CMD_LOAD, 24'sh7F_FFFF, 24'sh7F_FFFF, 0);
      push_item(knd_pkg::CMD_EVAL, 0, 0, 0);
      push_item(knd_pkg::CMD_LOAD, -24'sh80_0000, -24'sh80_0000, 0);
      push_item(knd_pkg::CMD_LOAD, 0, 0, 0);
      push_item(knd_pkg::CMD_LOAD, -1, 1, 0);
      push_item(knd_pkg::CMD_LOAD, 24'sh7F_FFFF, -24'sh80_0000, 0);
      push_item(knd_pkg::CMD_LOAD, 3, 4, 0);
      push_item(CMD_UNUSED, 24'sh55_5555, 24'shAA_AAAA, 8'hFF);
      for (int i = 0; i < 6; i++) push_item(knd_pkg::CMD_EVAL, 0, 0, 8'(i));
      push_item(knd_pkg::CMD_EVAL, 0, 0, 6);
      push_item(knd_pkg::CMD_EVAL, 0, 0, 8'hFF);
      drain();

      // duplicate points with no minimum radius
      set_config(1, 1, 24'hFF_FFFF, 0, 32'hFFFF_FFFF);
      push_item(knd_pkg::CMD_CLEAR, 0, 0, 0);
      push_item(knd_pkg::CMD_LOAD, 5, 5, 0);
      push_item(knd_pkg::CMD_LOAD, 5, 5, 0);
      push_item(knd_pkg::CMD_LOAD, 100, -100, 0);
      for (int i = 0; i < 3; i++) push_item(knd_pkg::CMD_EVAL, 0, 0, 8'(i));
      drain();

      // full store, k reaching the last list entry, with a long receiver hold-off
      set_config(17, 24'hFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
      push_item(knd_pkg::CMD_CLEAR, 0, 0, 0);
      for (int i = 0; i < STORE_DEPTH + 4; i++)
         push_item(knd_pkg::CMD_LOAD, rand_coord(), rand_coord(), 0);
      wait (pending_items.size() == 0);
      hold_go <= 1;
      for (int i = 0; i < 12; i++) push_item(knd_pkg::CMD_EVAL, 0, 0, 8'($urandom));
      push_item(knd_pkg::CMD_EVAL, 0, 0, 8'hFF);
      push_item(knd_pkg::CMD_EVAL, 0, 0, 0);
      drain();
      set_config(31, 65536, 256, 0, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++) push_item(knd_pkg::CMD_EVAL, 0, 0, 8'($urandom));
      drain();

      // random phases
      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 5))
            0: k = 0;
            1: k = 1;
            2: k = 17;
            3: k = 31;
            default: k = 5'($urandom_range(1, 17));
         endcase
         set_config(k, rand_inv(), rand_inv(), rand_min_r2(),
                    $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
         if ($urandom_range(0, 3) != 0) push_item(knd_pkg::CMD_CLEAR, 0, 0, 0);
         for (int i = $urandom_range(2, 24); i > 0; i--)
            push_item(knd_pkg::CMD_LOAD, rand_coord(), rand_coord(), 0);
         for (int i = $urandom_range(8, 20); i > 0; i--) begin
            case ($urandom_range(0, 19))
               0: push_item(CMD_UNUSED, rand_coord(), rand_coord(), 8'($urandom));
               1, 2, 3: push_item(knd_pkg::CMD_LOAD, rand_coord(), rand_coord(), 0);
               default: push_item(knd_pkg::CMD_EVAL, rand_coord(), rand_coord(), rand_index());
            endcase
         end
         drain();
      end

      if (errors == 0 && expected_densities.size() == 0)
         $display("knn_density_2d test passed");
      else
         $display("knn_density_2d test failed");
      $finish;
   end
endmodule

// File: knn_density_2d.f
+incdir+rtl
rtl/knd_pkg.sv
rtl/knd_sort_cell.sv
rtl/knd_dist.sv
rtl/knd_div.sv
rtl/knn_density_2d.sv
bench/tb_knn_density_2d.sv
